// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the dmpm_back module.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmpm_pkg.sv =====
// Types and constants of the DNA multi-pattern matcher.
// Used by every module of the block; depends on nothing.
package dmpm_pkg;

  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_TEXT   = 1'b1;
  localparam logic [7:0] HEADER_MARK = 8'h3E;
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [1:0] BASE_MASK   = 2'h3;

  typedef struct packed {
    logic        func;
    logic [11:0] node_index;
    logic [3:0]  edge_mask;
    logic [11:0] next_a;
    logic [11:0] next_c;
    logic [11:0] next_t;
    logic [11:0] next_g;
    logic [11:0] fail_link;
    logic        match_valid;
    logic [11:0] match_code;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] line_number;
    logic [11:0] match_id;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LINE,
    CMD_ROOT,
    CMD_BASE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [1:0]  base;
    logic [11:0] node_index;
    logic [3:0]  edge_mask;
    logic [11:0] next_a;
    logic [11:0] next_c;
    logic [11:0] next_t;
    logic [11:0] next_g;
    logic [11:0] fail_link;
    logic        match_valid;
    logic [11:0] match_code;
  } cmd_t;

  // one automaton node as stored
  typedef struct packed {
    logic [3:0]       edge_valid;
    logic [3:0][11:0] target;
    logic [11:0]      fail;
    logic             match_valid;
    logic [11:0]      match_id;
  } node_row_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_MATCH
  } back_state_e;

  function automatic logic is_base(input logic [7:0] b);
    logic [7:0] u;
    u = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'h20) : b;
    return (u == 8'h41) || (u == 8'h43) || (u == 8'h47) || (u == 8'h54);
  endfunction

endpackage

// ===== rtl/dmpm_front.sv =====
// Front end: accepts input items, tracks FASTA header lines and turns
// loads, newlines, '>' and bases into commands. Depends on dmpm_pkg.
module dmpm_front #(
  parameter int NODE_COUNT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dmpm_pkg::in_item_t in_data_i,
  output logic              push_o,
  output dmpm_pkg::cmd_t    push_cmd_o,
  input  logic              full_i
);

  logic hdr_q, hdr_d;
  logic accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    push_cmd_o             = '0;
    push_cmd_o.op          = dmpm_pkg::CMD_LOAD;
    push_cmd_o.base        = (in_data_i.text_byte[2:1]) & dmpm_pkg::BASE_MASK;
    push_cmd_o.node_index  = in_data_i.node_index;
    push_cmd_o.edge_mask   = in_data_i.edge_mask;
    push_cmd_o.next_a      = in_data_i.next_a;
    push_cmd_o.next_c      = in_data_i.next_c;
    push_cmd_o.next_t      = in_data_i.next_t;
    push_cmd_o.next_g      = in_data_i.next_g;
    push_cmd_o.fail_link   = in_data_i.fail_link;
    push_cmd_o.match_valid = in_data_i.match_valid;
    push_cmd_o.match_code  = in_data_i.match_code;
    push_o                 = 1'b0;
    hdr_d                  = hdr_q;
    if (accept) begin
      if (in_data_i.func == dmpm_pkg::FUNC_LOAD) begin
        // loads beyond the node store are dropped
        push_o = (32'(in_data_i.node_index) < NODE_COUNT);
      end else if (hdr_q) begin
        if (in_data_i.text_byte == dmpm_pkg::NEWLINE) begin
          push_o        = 1'b1;
          push_cmd_o.op = dmpm_pkg::CMD_LINE;
          hdr_d         = 1'b0;
        end
      end else if (in_data_i.text_byte == dmpm_pkg::HEADER_MARK) begin
        push_o        = 1'b1;
        push_cmd_o.op = dmpm_pkg::CMD_ROOT;
        hdr_d         = 1'b1;
      end else if (in_data_i.text_byte == dmpm_pkg::NEWLINE) begin
        push_o        = 1'b1;
        push_cmd_o.op = dmpm_pkg::CMD_LINE;
      end else if (dmpm_pkg::is_base(in_data_i.text_byte)) begin
        push_o        = 1'b1;
        push_cmd_o.op = dmpm_pkg::CMD_BASE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 1'b0;
    end else begin
      hdr_q <= hdr_d;
    end
  end

endmodule

// ===== rtl/dmpm_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on dmpm_pkg for the command type.
module dmpm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dmpm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dmpm_pkg::cmd_t cmd_o
);

  dmpm_pkg::cmd_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/dmpm_back.sv =====
// Back end: node store, failure-link walk, line counter and result register.
// Depends on dmpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmpm_back #(
  parameter int NODE_COUNT = 4096,
  parameter int LINE_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  dmpm_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmpm_pkg::out_item_t out_data_o
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW = $clog2(NODE_COUNT + 1);

  function automatic logic [11:0] clamp(input logic [11:0] n);
    return (32'(n) < NODE_COUNT) ? n : 12'd0;
  endfunction

  dmpm_pkg::node_row_t mem [NODE_COUNT];
  dmpm_pkg::node_row_t rd_q, wr_row;

  dmpm_pkg::back_state_e state_q, state_d;
  logic [11:0]          node_q, node_d, walk_q, walk_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic [1:0]           base_q, base_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic                 out_valid_q, out_valid_d;
  dmpm_pkg::out_item_t  out_q, out_d;
  logic                 rd_en, wr_en;
  logic [11:0]          rd_node;
  logic                 edge_hit, out_free;
  logic [LINE_BITS+31:0] line_wide;

  assign edge_hit  = rd_q.edge_valid[base_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign line_wide = (LINE_BITS + 32)'(line_q);

  always_comb begin
    wr_row.edge_valid  = cmd_i.edge_mask;
    wr_row.target[0]   = cmd_i.next_a;
    wr_row.target[1]   = cmd_i.next_c;
    wr_row.target[2]   = cmd_i.next_t;
    wr_row.target[3]   = cmd_i.next_g;
    wr_row.fail        = cmd_i.fail_link;
    wr_row.match_valid = cmd_i.match_valid;
    wr_row.match_id    = cmd_i.match_code;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmpm_pkg::BK_IDLE: begin
        if (!empty_i && cmd_i.op == dmpm_pkg::CMD_BASE) state_d = dmpm_pkg::BK_WALK;
      end
      dmpm_pkg::BK_WALK: begin
        if (edge_hit || steps_q == SW'(NODE_COUNT)) state_d = dmpm_pkg::BK_MATCH;
      end
      dmpm_pkg::BK_MATCH: begin
        if (!rd_q.match_valid || out_free) state_d = dmpm_pkg::BK_IDLE;
      end
      default: state_d = dmpm_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_node     = walk_q;
    node_d      = node_q;
    walk_d      = walk_q;
    steps_d     = steps_q;
    base_d      = base_q;
    line_d      = line_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      dmpm_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            dmpm_pkg::CMD_LOAD: wr_en = 1'b1;
            dmpm_pkg::CMD_LINE: begin
              if (line_q != '1) line_d = line_q + 1'b1;
            end
            dmpm_pkg::CMD_ROOT: node_d = 12'd0;
            default: begin
              base_d  = cmd_i.base;
              walk_d  = node_q;
              steps_d = '0;
              rd_en   = 1'b1;
              rd_node = node_q;
            end
          endcase
        end
      end
      dmpm_pkg::BK_WALK: begin
        rd_en = 1'b1;
        if (edge_hit) begin
          walk_d = clamp(rd_q.target[base_q]);
        end else if (steps_q == SW'(NODE_COUNT)) begin
          walk_d = 12'd0;
        end else begin
          walk_d  = clamp(rd_q.fail);
          steps_d = steps_q + 1'b1;
        end
        rd_node = walk_d;
      end
      dmpm_pkg::BK_MATCH: begin
        if (!rd_q.match_valid) begin
          node_d = walk_q;
        end else if (out_free) begin
          node_d            = walk_q;
          out_valid_d       = 1'b1;
          out_d.match_id    = rd_q.match_id;
          out_d.line_number = (|line_wide[LINE_BITS+31:32]) ? 32'hFFFF_FFFF
                                                              : line_wide[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(cmd_i.node_index)] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[AW'(rd_node)];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmpm_pkg::BK_IDLE;
      node_q      <= 12'd0;
      walk_q      <= 12'd0;
      steps_q     <= '0;
      base_q      <= 2'd0;
      line_q      <= LINE_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      walk_q      <= walk_d;
      steps_q     <= steps_d;
      base_q      <= base_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_pop_only_idle, pop_o, state_q == dmpm_pkg::BK_IDLE, "pop outside idle")
  `ASSERT_IMPL(a_node_in_range, 1'b1, 32'(node_q) < NODE_COUNT, "current node out of range")
  `ASSERT_NEXT(a_walk_bounded, state_q == dmpm_pkg::BK_WALK,
               32'(steps_q) <= NODE_COUNT, "failure walk past bound")

endmodule

// ===== rtl/dna_multi_pattern_matcher.sv =====
// Aho-Corasick DNA matcher: top level tying front end, queue and back end.
// Depends on dmpm_pkg, dmpm_front, dmpm_fifo and dmpm_back.
//
// Load items write one node row each. A newline or a '>' becomes one
// back-end command; an ignored byte is dropped at the front end and
// never reaches the back end. A base walks its failure links, and each
// step is a registered read of the node memory. Results leave through
// an output register, and a two-entry command queue lets the input side
// keep accepting while the walk runs, until the queue is full. No
// clearing pass is needed after reset.
module dna_multi_pattern_matcher #(
  parameter int NODE_COUNT = 4096,
  parameter int LINE_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dmpm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmpm_pkg::out_item_t out_data_o
);

  logic           push, full, pop, empty;
  dmpm_pkg::cmd_t push_cmd, head_cmd;

  dmpm_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  dmpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  dmpm_back #(.NODE_COUNT(NODE_COUNT), .LINE_BITS(LINE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
